[rtl/core/overwrite_ring_buffer_burst_read_assert.svh]
// Assertion macros for the ring buffer block.
`ifndef OVERWRITE_RING_BUFFER_BURST_READ_ASSERT_SVH
`define OVERWRITE_RING_BUFFER_BURST_READ_ASSERT_SVH

`ifndef SYNTHESIS

// Clocked property, checked outside reset.
`define ORB_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ring buffer: property violated");

// Clocked property, checked during reset too.
`define ORB_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("ring buffer: invariant violated");

`else

`define ORB_ASSERT(lbl, clk, rst_n, prop)
`define ORB_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

[rtl/core/orbbr_pkg.sv]
package orbbr_pkg;

    localparam int BYTE_W   = 8;
    localparam int SIZE_W   = 8;
    localparam int FILL_W   = 8;
    localparam int STATUS_W = 2;

    localparam logic OP_PUSH = 1'b0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH_WR,
        S_PUSH_DROP,
        S_CHECK,
        S_RESULT,
        S_BURST
    } t_state;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_SHORT = 2'd1,
        ST_OVER  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC
    } t_cnt_op;

    typedef struct packed {
        logic    use_rptr;
        t_cnt_op cnt_op;
    } t_step_cmd;

    typedef struct packed {
        logic over_burst;
        logic short_data;
        logic zero_size;
        logic at_full;
    } t_step_flags;

endpackage

[rtl/core/orbbr_if.sv]
interface orbbr_in_if import orbbr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              operation;
    logic [BYTE_W-1:0] in_byte;
    logic [SIZE_W-1:0] read_size;

    modport source (output valid, operation, in_byte, read_size, input ready);
    modport sink   (input valid, operation, in_byte, read_size, output ready);
endinterface

interface orbbr_out_if import orbbr_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [BYTE_W-1:0]   out_byte;
    logic                byte_valid;
    logic                last;
    logic [STATUS_W-1:0] status;
    logic                dropped_oldest;
    logic                full_res;
    logic                empty_res;
    logic [FILL_W-1:0]   fill_count;

    modport source (output valid, out_byte, byte_valid, last, status, dropped_oldest,
                    full_res, empty_res, fill_count, input ready);
    modport sink   (input valid, out_byte, byte_valid, last, status, dropped_oldest,
                    full_res, empty_res, fill_count, output ready);
endinterface

[rtl/core/orbbr_mem.sv]
module orbbr_mem import orbbr_pkg::*; #(
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [BYTE_W-1:0]        i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [BYTE_W-1:0]        o_rdata
);

    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Hold read data until the next read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/orbbr_step.sv]
module orbbr_step import orbbr_pkg::*; #(
    parameter int DEPTH     = 128,
    parameter int MAX_BURST = 64
) (
    input  t_step_cmd                  i_cmd,
    input  logic [$clog2(DEPTH)-1:0]   i_rptr,
    input  logic [$clog2(DEPTH)-1:0]   i_wptr,
    input  logic [$clog2(DEPTH+1)-1:0] i_count,
    input  logic [SIZE_W-1:0]          i_size,
    output logic [$clog2(DEPTH)-1:0]   o_ptr_next,
    output logic [$clog2(DEPTH+1)-1:0] o_count_next,
    output t_step_flags                o_flags
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;

    logic [PTR_W-1:0] ptr_sel;

    // Shared pointer advance with wrap at DEPTH.
    always_comb begin
        ptr_sel    = i_cmd.use_rptr ? i_rptr : i_wptr;
        o_ptr_next = (ptr_sel == PTR_W'(DEPTH - 1)) ? '0 : ptr_sel + PTR_W'(1);
    end

    always_comb begin
        case (i_cmd.cnt_op)
            CNT_INC: o_count_next = i_count + CNT_W'(1);
            CNT_DEC: o_count_next = i_count - CNT_W'(1);
            default: o_count_next = i_count;
        endcase
    end

    always_comb begin
        o_flags.over_burst = i_size > SIZE_W'(MAX_BURST);
        o_flags.short_data = CMP_W'(i_count) < CMP_W'(i_size);
        o_flags.zero_size  = i_size == '0;
        o_flags.at_full    = i_count == CNT_W'(DEPTH);
    end

endmodule

[rtl/core/orbbr_seq.sv]
module orbbr_seq import orbbr_pkg::*; #(
    parameter int DEPTH     = 128,
    parameter int MAX_BURST = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    orbbr_in_if.sink                   i_in,
    orbbr_out_if.source                o_out,
    output t_step_cmd                  o_step_cmd,
    output logic [$clog2(DEPTH)-1:0]   o_rptr,
    output logic [$clog2(DEPTH)-1:0]   o_wptr,
    output logic [$clog2(DEPTH+1)-1:0] o_count,
    output logic [SIZE_W-1:0]          o_size,
    input  logic [$clog2(DEPTH)-1:0]   i_ptr_next,
    input  logic [$clog2(DEPTH+1)-1:0] i_count_next,
    input  t_step_flags                i_flags,
    output logic                       o_mem_we,
    output logic [$clog2(DEPTH)-1:0]   o_mem_waddr,
    output logic [BYTE_W-1:0]          o_mem_wdata,
    output logic                       o_mem_re,
    output logic [$clog2(DEPTH)-1:0]   o_mem_raddr,
    input  logic [BYTE_W-1:0]          i_mem_rdata
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int REM_W = $clog2(MAX_BURST + 1);

    t_state              r_state,   n_state;
    logic [PTR_W-1:0]    r_rptr,    n_rptr;
    logic [PTR_W-1:0]    r_wptr,    n_wptr;
    logic [CNT_W-1:0]    r_count,   n_count;
    logic [BYTE_W-1:0]   r_byte,    n_byte;
    logic [SIZE_W-1:0]   r_size,    n_size;
    logic [REM_W-1:0]    r_remain,  n_remain;
    t_status             r_status,  n_status;
    logic                r_dropped, n_dropped;

    logic                r_out_valid,   n_out_valid;
    logic [BYTE_W-1:0]   r_out_byte,    n_out_byte;
    logic                r_out_bvalid,  n_out_bvalid;
    logic                r_out_last,    n_out_last;
    t_status             r_out_status,  n_out_status;
    logic                r_out_dropped, n_out_dropped;
    logic                r_out_full,    n_out_full;
    logic                r_out_empty,   n_out_empty;
    logic [FILL_W-1:0]   r_out_fill,    n_out_fill;

    logic out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rptr      <= '0;
            r_wptr      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rptr      <= n_rptr;
            r_wptr      <= n_wptr;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte        <= n_byte;
        r_size        <= n_size;
        r_remain      <= n_remain;
        r_status      <= n_status;
        r_dropped     <= n_dropped;
        r_out_byte    <= n_out_byte;
        r_out_bvalid  <= n_out_bvalid;
        r_out_last    <= n_out_last;
        r_out_status  <= n_out_status;
        r_out_dropped <= n_out_dropped;
        r_out_full    <= n_out_full;
        r_out_empty   <= n_out_empty;
        r_out_fill    <= n_out_fill;
    end

    always_comb begin
        n_state       = r_state;
        n_rptr        = r_rptr;
        n_wptr        = r_wptr;
        n_count       = r_count;
        n_byte        = r_byte;
        n_size        = r_size;
        n_remain      = r_remain;
        n_status      = r_status;
        n_dropped     = r_dropped;
        n_out_valid   = r_out_valid;
        n_out_byte    = r_out_byte;
        n_out_bvalid  = r_out_bvalid;
        n_out_last    = r_out_last;
        n_out_status  = r_out_status;
        n_out_dropped = r_out_dropped;
        n_out_full    = r_out_full;
        n_out_empty   = r_out_empty;
        n_out_fill    = r_out_fill;

        o_step_cmd.use_rptr = 1'b1;
        o_step_cmd.cnt_op   = CNT_HOLD;
        o_mem_we            = 1'b0;
        o_mem_waddr         = r_wptr;
        o_mem_wdata         = r_byte;
        o_mem_re            = 1'b0;
        o_mem_raddr         = r_rptr;
        i_in.ready          = 1'b0;

        out_free = !r_out_valid || o_out.ready;
        if (o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid) begin
                    n_byte  = i_in.in_byte;
                    n_size  = i_in.read_size;
                    n_state = (i_in.operation == OP_PUSH) ? S_PUSH_WR : S_CHECK;
                end
            end
            S_PUSH_WR: begin
                o_step_cmd.use_rptr = 1'b0;
                o_step_cmd.cnt_op   = i_flags.at_full ? CNT_HOLD : CNT_INC;
                o_mem_we            = 1'b1;
                n_wptr              = i_ptr_next;
                n_count             = i_count_next;
                n_dropped           = i_flags.at_full;
                n_status            = ST_OK;
                n_state             = i_flags.at_full ? S_PUSH_DROP : S_RESULT;
            end
            S_PUSH_DROP: begin
                // Drop the oldest byte.
                n_rptr  = i_ptr_next;
                n_state = S_RESULT;
            end
            S_CHECK: begin
                n_dropped = 1'b0;
                n_status  = ST_OK;
                if (i_flags.over_burst) begin
                    n_status = ST_OVER;
                    n_state  = S_RESULT;
                end else if (i_flags.short_data) begin
                    n_status = ST_SHORT;
                    n_state  = S_RESULT;
                end else if (i_flags.zero_size) begin
                    n_state = S_RESULT;
                end else begin
                    o_mem_re = 1'b1;
                    n_remain = REM_W'(r_size);
                    n_state  = S_BURST;
                end
            end
            S_RESULT: begin
                if (out_free) begin
                    n_out_valid   = 1'b1;
                    n_out_byte    = '0;
                    n_out_bvalid  = 1'b0;
                    n_out_last    = 1'b1;
                    n_out_status  = r_status;
                    n_out_dropped = r_dropped;
                    n_out_full    = i_flags.at_full;
                    n_out_empty   = r_count == '0;
                    n_out_fill    = FILL_W'(r_count);
                    n_state       = S_IDLE;
                end
            end
            S_BURST: begin
                o_step_cmd.cnt_op = CNT_DEC;
                if (out_free) begin
                    n_out_valid   = 1'b1;
                    n_out_byte    = i_mem_rdata;
                    n_out_bvalid  = 1'b1;
                    n_out_last    = r_remain == REM_W'(1);
                    n_out_status  = ST_OK;
                    n_out_dropped = 1'b0;
                    n_out_full    = i_count_next == CNT_W'(DEPTH);
                    n_out_empty   = i_count_next == '0;
                    n_out_fill    = FILL_W'(i_count_next);
                    n_rptr        = i_ptr_next;
                    n_count       = i_count_next;
                    n_remain      = r_remain - REM_W'(1);
                    if (r_remain == REM_W'(1)) begin
                        n_state = S_IDLE;
                    end else begin
                        // Fetch the next byte behind this beat.
                        o_mem_re    = 1'b1;
                        o_mem_raddr = i_ptr_next;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_rptr  = r_rptr;
    assign o_wptr  = r_wptr;
    assign o_count = r_count;
    assign o_size  = r_size;

    assign o_out.valid          = r_out_valid;
    assign o_out.out_byte       = r_out_byte;
    assign o_out.byte_valid     = r_out_bvalid;
    assign o_out.last           = r_out_last;
    assign o_out.status         = r_out_status;
    assign o_out.dropped_oldest = r_out_dropped;
    assign o_out.full_res       = r_out_full;
    assign o_out.empty_res      = r_out_empty;
    assign o_out.fill_count     = r_out_fill;

endmodule

[rtl/core/overwrite_ring_buffer_burst_read.sv]
// Receive-side byte ring buffer with overwrite of the oldest byte and all-or-nothing
// burst reads. Each input beat is either a push (store in_byte at the tail; when
// the buffer already holds DEPTH bytes the head advances too and dropped_oldest is
// set) or a read request for read_size bytes. A read above MAX_BURST returns one
// beat with the over-limit status, a read for more than is held returns one beat
// with the not-enough-data status, a read of zero returns one empty OK beat, and
// a granted read returns read_size beats of data from the head with last on the
// final one. Every result beat reports full, empty and the fill count (low 8 bits)
// as they stand after that beat. Items are handled one at a time: the input is
// not ready from acceptance until the last result beat is loaded into the output
// register. A push goes through the write state and then the result state, with
// the drop state between them when it drops the oldest byte, since the pointer
// advance and count update share one step unit and the tail and head advances are
// done in turn. A refused or empty read goes through the check state and then the
// result state. A granted read of N bytes first checks the request and fetches the
// first byte through the single registered read port of the store, then returns
// one beat per cycle while the sink takes each beat. A result beat waiting in the
// output register does not stop the next item from being accepted. After reset
// the buffer is empty and ready at once; no clearing pass is needed.
`include "overwrite_ring_buffer_burst_read_assert.svh"

module overwrite_ring_buffer_burst_read import orbbr_pkg::*; #(
    parameter int DEPTH     = 128,
    parameter int MAX_BURST = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    orbbr_in_if.sink    i_in,
    orbbr_out_if.source o_out
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Sequencer to step unit
    t_step_cmd   step_cmd;
    t_step_flags step_flags;
    logic [PTR_W-1:0]  rptr;
    logic [PTR_W-1:0]  wptr;
    logic [PTR_W-1:0]  ptr_next;
    logic [CNT_W-1:0]  count;
    logic [CNT_W-1:0]  count_next;
    logic [SIZE_W-1:0] size;

    // Sequencer to byte store
    logic              mem_we;
    logic [PTR_W-1:0]  mem_waddr;
    logic [BYTE_W-1:0] mem_wdata;
    logic              mem_re;
    logic [PTR_W-1:0]  mem_raddr;
    logic [BYTE_W-1:0] mem_rdata;

    orbbr_seq #(
        .DEPTH     (DEPTH),
        .MAX_BURST (MAX_BURST)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_out        (o_out),
        .o_step_cmd   (step_cmd),
        .o_rptr       (rptr),
        .o_wptr       (wptr),
        .o_count      (count),
        .o_size       (size),
        .i_ptr_next   (ptr_next),
        .i_count_next (count_next),
        .i_flags      (step_flags),
        .o_mem_we     (mem_we),
        .o_mem_waddr  (mem_waddr),
        .o_mem_wdata  (mem_wdata),
        .o_mem_re     (mem_re),
        .o_mem_raddr  (mem_raddr),
        .i_mem_rdata  (mem_rdata)
    );

    // Shared pointer, count and request-check unit
    orbbr_step #(
        .DEPTH     (DEPTH),
        .MAX_BURST (MAX_BURST)
    ) u_step (
        .i_cmd        (step_cmd),
        .i_rptr       (rptr),
        .i_wptr       (wptr),
        .i_count      (count),
        .i_size       (size),
        .o_ptr_next   (ptr_next),
        .o_count_next (count_next),
        .o_flags      (step_flags)
    );

    // Byte store, one write and one registered read port
    orbbr_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // An accepted item blocks the input for at least the following cycle.
    `ORB_ASSERT(a_busy_after_accept, i_clk, i_rst_n,
        i_in.valid && i_in.ready |=> !i_in.ready)

    // While a data beat that is not the last is offered, the burst still holds the input.
    `ORB_ASSERT(a_burst_holds_input, i_clk, i_rst_n,
        o_out.valid && o_out.byte_valid && !o_out.last |-> !i_in.ready)

    // Data beats are always OK and never flag a drop.
    `ORB_ASSERT(a_data_beat_ok, i_clk, i_rst_n,
        o_out.valid && o_out.byte_valid |-> o_out.status == ST_OK && !o_out.dropped_oldest)

    // Full and empty are never reported together.
    `ORB_ASSERT(a_full_empty_excl, i_clk, i_rst_n,
        !(o_out.valid && o_out.full_res && o_out.empty_res))

    // Reset leaves the output register empty.
    `ORB_ASSERT_ALWAYS(a_reset_clears_out, i_clk, !i_rst_n |=> !o_out.valid)

endmodule
